// ----- rtl/msbs_pkg.sv -----
// ----------------------------------------------------------------------------
// msbs_pkg: shared definitions for the multi-signature byte scanner
// Sizes, operation codes and the record that passes from the match front end
// to the result back end through the hit queue.
// ----------------------------------------------------------------------------
package msbs_pkg;

    // Table geometry and scan window
    localparam int NUM_SIGS    = 8;
    localparam int MAX_SIG_LEN = 32;
    localparam int SCAN_LIMIT  = 65536;

    // Fixed field widths of the ports
    localparam int OP_FIELD_W   = 2;
    localparam int SLOT_FIELD_W = 3;
    localparam int POS_FIELD_W  = 5;
    localparam int BYTE_W       = 8;
    localparam int LEN_FIELD_W  = 6;
    localparam int OFFSET_W     = 16;

    // Derived internal widths
    localparam int SLOT_W     = $clog2(NUM_SIGS);
    localparam int BYTE_IDX_W = $clog2(MAX_SIG_LEN);
    localparam int LEN_W      = $clog2(MAX_SIG_LEN + 1);
    localparam int POS_W      = $clog2(SCAN_LIMIT + 1);

    // Hit queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [OP_FIELD_W-1:0] {
        OP_LOAD_BYTE = 2'd0,
        OP_SET_LEN   = 2'd1,
        OP_SCAN      = 2'd2,
        OP_NEW_FILE  = 2'd3
    } t_msbs_op;

    // One scanned byte that hit at least one signature
    typedef struct packed {
        logic [NUM_SIGS-1:0]            hits;
        logic [OFFSET_W-1:0]            end_pos;
        logic [NUM_SIGS-1:0][LEN_W-1:0] lens;
    } t_msbs_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_msbs_qstat;

endpackage

// ----- rtl/msbs_front.sv -----
// ----------------------------------------------------------------------------
// msbs_front: item intake and signature comparison
// Holds the signature table, the lengths and the recent data bytes, compares
// every slot against the newest bytes and pushes hit records to the queue.
// ----------------------------------------------------------------------------
module msbs_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [msbs_pkg::OP_FIELD_W-1:0]        i_operation,
    input  logic [msbs_pkg::SLOT_FIELD_W-1:0]      i_sig_slot,
    input  logic [msbs_pkg::POS_FIELD_W-1:0]       i_byte_position,
    input  logic [msbs_pkg::BYTE_W-1:0]            i_byte_value,
    input  logic [msbs_pkg::LEN_FIELD_W-1:0]       i_sig_length,
    input  msbs_pkg::t_msbs_qstat                  i_qstat,
    output logic                                   o_push,
    output msbs_pkg::t_msbs_entry                  o_entry
);

    localparam int NS = msbs_pkg::NUM_SIGS;
    localparam int ML = msbs_pkg::MAX_SIG_LEN;
    localparam int LW = msbs_pkg::LEN_W;
    localparam int PW = msbs_pkg::POS_W;

    logic [ML-1:0][msbs_pkg::BYTE_W-1:0] r_sig [NS];
    logic [NS-1:0][LW-1:0]               r_len;
    logic [LW-1:0]                       r_shift [NS];
    logic [ML-1:0]                       r_mask [NS];
    logic [ML-1:0][msbs_pkg::BYTE_W-1:0] r_hist;
    logic [LW-1:0]                       r_fill;
    logic [PW-1:0]                       r_pos;

    logic [ML-1:0][msbs_pkg::BYTE_W-1:0] n_hist;
    logic [LW-1:0]                       n_fill;
    logic [PW-1:0]                       n_pos;
    logic [LW-1:0]                       n_len;
    logic [LW-1:0]                       n_shift;
    logic [ML-1:0]                       n_mask;

    msbs_pkg::t_msbs_op                  op;
    logic                                accept;
    logic                                in_range;
    logic                                slot_ok;
    logic                                pos_ok;
    logic [NS-1:0]                       hits;
    logic [ML-1:0][msbs_pkg::BYTE_W-1:0] win [NS];
    logic [ML-1:0]                       byte_ok [NS];

    assign o_ready  = !i_qstat.full;
    assign accept   = i_valid && o_ready;
    assign op       = msbs_pkg::t_msbs_op'(i_operation);
    assign in_range = (r_pos < PW'(msbs_pkg::SCAN_LIMIT));
    assign slot_ok  = (int'(i_sig_slot) < NS);
    assign pos_ok   = (int'(i_byte_position) < ML);

    // Newest byte enters at the top, oldest falls off the bottom
    assign n_hist = {i_byte_value, r_hist[ML-1:1]};
    assign n_fill = (r_fill == LW'(ML)) ? r_fill : r_fill + 1'b1;
    assign n_pos  = r_pos + 1'b1;

    always_comb begin
        n_len   = (int'(i_sig_length) > ML) ? LW'(ML) : LW'(i_sig_length);
        n_shift = LW'(ML - int'(n_len));
        for (int k = 0; k < ML; k++) begin
            n_mask[k] = (k < int'(n_len));
        end
    end

    // One comparator lane per slot: align the window to the signature start
    for (genvar s = 0; s < NS; s++) begin : g_lane
        assign win[s] = n_hist >> {r_shift[s], 3'b000};
        for (genvar k = 0; k < ML; k++) begin : g_byte
            assign byte_ok[s][k] = !r_mask[s][k] || (win[s][k] == r_sig[s][k]);
        end
        assign hits[s] = (r_len[s] != '0) && (r_len[s] <= n_fill) && (&byte_ok[s]);
    end

    assign o_push        = accept && (op == msbs_pkg::OP_SCAN) && in_range && (|hits);
    assign o_entry.hits    = hits;
    assign o_entry.end_pos = n_pos[msbs_pkg::OFFSET_W-1:0];
    assign o_entry.lens    = r_len;

    // Control state: lengths, fill level and file position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_fill <= '0;
            r_pos  <= '0;
            for (int s = 0; s < NS; s++) begin
                r_shift[s] <= LW'(ML);
                r_mask[s]  <= '0;
            end
        end else if (accept) begin
            unique case (op)
                msbs_pkg::OP_SET_LEN: begin
                    if (slot_ok) begin
                        r_len[i_sig_slot[msbs_pkg::SLOT_W-1:0]]   <= n_len;
                        r_shift[i_sig_slot[msbs_pkg::SLOT_W-1:0]] <= n_shift;
                        r_mask[i_sig_slot[msbs_pkg::SLOT_W-1:0]]  <= n_mask;
                    end
                end
                msbs_pkg::OP_SCAN: begin
                    if (in_range) begin
                        r_fill <= n_fill;
                        r_pos  <= n_pos;
                    end
                end
                msbs_pkg::OP_NEW_FILE: begin
                    r_fill <= '0;
                    r_pos  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload: signature bytes and data history
    always_ff @(posedge i_clk) begin
        if (accept && (op == msbs_pkg::OP_LOAD_BYTE) && slot_ok && pos_ok) begin
            r_sig[i_sig_slot[msbs_pkg::SLOT_W-1:0]]
                 [i_byte_position[msbs_pkg::BYTE_IDX_W-1:0]] <= i_byte_value;
        end
        if (accept && (op == msbs_pkg::OP_SCAN) && in_range) begin
            r_hist <= n_hist;
        end
    end

endmodule

// ----- rtl/msbs_queue.sv -----
// ----------------------------------------------------------------------------
// msbs_queue: hit record queue
// Short first-in first-out store that decouples the comparator front end
// from the result back end.
// ----------------------------------------------------------------------------
module msbs_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  msbs_pkg::t_msbs_entry i_entry,
    input  logic                  i_pop,
    output msbs_pkg::t_msbs_entry o_head,
    output msbs_pkg::t_msbs_qstat o_qstat
);

    localparam int QW = msbs_pkg::QPTR_W;

    msbs_pkg::t_msbs_entry r_mem [msbs_pkg::QUEUE_DEPTH];
    logic [QW:0]           r_wr;
    logic [QW:0]           r_rd;

    assign o_qstat.empty = (r_wr == r_rd);
    assign o_qstat.full  = (r_wr[QW] != r_rd[QW]) && (r_wr[QW-1:0] == r_rd[QW-1:0]);
    assign o_head        = r_mem[r_rd[QW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_qstat.full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_qstat.empty) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_qstat.full) begin
            r_mem[r_wr[QW-1:0]] <= i_entry;
        end
    end

endmodule

// ----- rtl/msbs_back.sv -----
// ----------------------------------------------------------------------------
// msbs_back: result sequencer
// Walks the hit bits of the queue head in ascending slot order and drives one
// result per cycle, while the receiver is ready, through the output register.
// ----------------------------------------------------------------------------
module msbs_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  msbs_pkg::t_msbs_entry                 i_head,
    input  msbs_pkg::t_msbs_qstat                 i_qstat,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [msbs_pkg::SLOT_FIELD_W-1:0]     o_match_slot,
    output logic [msbs_pkg::OFFSET_W-1:0]         o_match_offset,
    output logic [msbs_pkg::LEN_FIELD_W-1:0]      o_match_length,
    output logic                                  o_last
);

    localparam int NS = msbs_pkg::NUM_SIGS;

    logic [NS-1:0]                       r_done;
    logic                                r_valid;
    logic [msbs_pkg::SLOT_FIELD_W-1:0]   r_slot;
    logic [msbs_pkg::OFFSET_W-1:0]       r_offset;
    logic [msbs_pkg::LEN_FIELD_W-1:0]    r_length;
    logic                                r_last;

    logic [NS-1:0]                       rem;
    logic [NS-1:0]                       pick;
    logic [msbs_pkg::SLOT_W-1:0]         sel;
    logic [msbs_pkg::LEN_W-1:0]          len;
    logic                                adv;
    logic                                fire;
    logic                                fin;

    assign rem  = i_head.hits & ~r_done;
    assign pick = rem & (~rem + 1'b1);

    always_comb begin
        sel = '0;
        for (int s = NS - 1; s >= 0; s--) begin
            if (rem[s]) begin
                sel = msbs_pkg::SLOT_W'(s);
            end
        end
    end

    assign len   = i_head.lens[sel];
    assign adv   = !r_valid || i_ready;
    assign fire  = adv && !i_qstat.empty;
    assign fin   = ((rem & ~pick) == '0);
    assign o_pop = fire && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (adv) begin
                r_valid <= fire;
            end
            if (fire) begin
                r_done <= fin ? '0 : (r_done | pick);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_slot   <= msbs_pkg::SLOT_FIELD_W'(sel);
            r_offset <= i_head.end_pos - msbs_pkg::OFFSET_W'(len);
            r_length <= msbs_pkg::LEN_FIELD_W'(len);
            r_last   <= fin;
        end
    end

    assign o_valid        = r_valid;
    assign o_match_slot   = r_slot;
    assign o_match_offset = r_offset;
    assign o_match_length = r_length;
    assign o_last         = r_last;

endmodule

// ----- rtl/multi_signature_byte_scanner.sv -----
// ----------------------------------------------------------------------------
// multi_signature_byte_scanner: streaming multi-pattern exact byte matcher
// The first result of a scanned byte passes the hit queue and the output
// register. Throughput: one item per cycle; a byte with n hits yields n
// results, and input stalls only while the 2-entry hit queue is full.
// Reset: synchronous, active low; disables every slot, clears the file
// position, empties the queue and drops the output item. No clearing pass.
// ----------------------------------------------------------------------------
module multi_signature_byte_scanner (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [msbs_pkg::OP_FIELD_W-1:0]       i_operation,
    input  logic [msbs_pkg::SLOT_FIELD_W-1:0]     i_sig_slot,
    input  logic [msbs_pkg::POS_FIELD_W-1:0]      i_byte_position,
    input  logic [msbs_pkg::BYTE_W-1:0]           i_byte_value,
    input  logic [msbs_pkg::LEN_FIELD_W-1:0]      i_sig_length,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [msbs_pkg::SLOT_FIELD_W-1:0]     o_match_slot,
    output logic [msbs_pkg::OFFSET_W-1:0]         o_match_offset,
    output logic [msbs_pkg::LEN_FIELD_W-1:0]      o_match_length,
    output logic                                  o_last
);

    // Front to queue: a hit record for each scanned byte with any match
    logic                  push;
    msbs_pkg::t_msbs_entry entry;

    // Queue to back: head record, pop and fill status
    logic                  pop;
    msbs_pkg::t_msbs_entry head;
    msbs_pkg::t_msbs_qstat qstat;

    // Front end: take every item, update the signature table and the data
    // window, and compare all slots in parallel against the newest bytes.
    // Only bytes that hit something reach the queue, so non-matching bytes
    // cost the back end nothing.
    msbs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_sig_slot      (i_sig_slot),
        .i_byte_position (i_byte_position),
        .i_byte_value    (i_byte_value),
        .i_sig_length    (i_sig_length),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_entry         (entry)
    );

    // Queue: hold hit records with a snapshot of the lengths, so that later
    // length writes cannot alter results still waiting to be sent.
    msbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    // Back end: emit one result per hit bit, lowest slot first, and flag
    // the final one of the byte; advance the queue on that final result.
    msbs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_match_slot   (o_match_slot),
        .o_match_offset (o_match_offset),
        .o_match_length (o_match_length),
        .o_last         (o_last)
    );

endmodule

// ----- rtl/msbs_checker.sv -----
// ----------------------------------------------------------------------------
// msbs_checker: port-level checks for the byte scanner
// Watches the result channel for reset, stall and ordering behaviour.
// ----------------------------------------------------------------------------
module msbs_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic [msbs_pkg::SLOT_FIELD_W-1:0]     o_match_slot,
    input logic [msbs_pkg::OFFSET_W-1:0]         o_match_offset,
    input logic [msbs_pkg::LEN_FIELD_W-1:0]      o_match_length,
    input logic                                  o_last
);

    logic [msbs_pkg::OFFSET_W-1:0] match_end;

    assign match_end = o_match_offset + msbs_pkg::OFFSET_W'(o_match_length);

    // Drop any pending result on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_match_slot)
            && $stable(o_match_offset) && $stable(o_match_length) && $stable(o_last))
        else $error("stalled result changed");

    // Results of one byte follow back to back in ascending slot order
    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && (o_match_slot > $past(o_match_slot)))
        else $error("results of one byte out of order");

    // Results of one byte all end at the same file position
    a_same_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> match_end == $past(match_end))
        else $error("results of one byte disagree on end position");

endmodule

bind multi_signature_byte_scanner msbs_checker u_msbs_checker (.*);

// ----- dv/multi_signature_byte_scanner_tb.sv -----
// ----------------------------------------------------------------------------
// multi_signature_byte_scanner_tb: self-checking bench for the byte scanner
// Drive load, length, scan and new-file items through the input handshake,
// predict every match in the bench, and compare each result item field by
// field. Both sides idle at random; one stretch runs with no idling, and one
// long receiver hold-off fills the hit queue so that the input stalls.
// ----------------------------------------------------------------------------
module multi_signature_byte_scanner_tb;

    localparam int NUM_SIGS     = msbs_pkg::NUM_SIGS;
    localparam int MAX_SIG_LEN  = msbs_pkg::MAX_SIG_LEN;
    localparam int SCAN_LIMIT   = msbs_pkg::SCAN_LIMIT;
    localparam int OP_FIELD_W   = msbs_pkg::OP_FIELD_W;
    localparam int SLOT_FIELD_W = msbs_pkg::SLOT_FIELD_W;
    localparam int POS_FIELD_W  = msbs_pkg::POS_FIELD_W;
    localparam int BYTE_W       = msbs_pkg::BYTE_W;
    localparam int LEN_FIELD_W  = msbs_pkg::LEN_FIELD_W;
    localparam int OFFSET_W     = msbs_pkg::OFFSET_W;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int IDLE_PERCENT    = 36;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int LEN_FIELD_MAX   = (1 << LEN_FIELD_W) - 1;

    // One reported match, as it leaves the block
    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic [OFFSET_W-1:0]     offset;
        logic [LEN_FIELD_W-1:0]  length;
        logic                    last;
    } t_match;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [OP_FIELD_W-1:0]   i_operation;
    logic [SLOT_FIELD_W-1:0] i_sig_slot;
    logic [POS_FIELD_W-1:0]  i_byte_position;
    logic [BYTE_W-1:0]       i_byte_value;
    logic [LEN_FIELD_W-1:0]  i_sig_length;
    logic                    o_valid;
    logic                    i_ready;
    logic [SLOT_FIELD_W-1:0] o_match_slot;
    logic [OFFSET_W-1:0]     o_match_offset;
    logic [LEN_FIELD_W-1:0]  o_match_length;
    logic                    o_last;

    // Bench copy of the signature table, the data window and the file position
    logic [BYTE_W-1:0]      sig_table     [NUM_SIGS][MAX_SIG_LEN];
    bit                     sig_loaded    [NUM_SIGS][MAX_SIG_LEN];
    logic [LEN_FIELD_W-1:0] sig_len       [NUM_SIGS];
    logic [BYTE_W-1:0]      recent_window [MAX_SIG_LEN];
    int                     file_pos;

    t_match            expected_matches [$];
    logic [BYTE_W-1:0] alphabet [4];

    int items_sent        = 0;
    int error_count       = 0;
    int stall_count       = 0;
    bit tx_idle_on        = 1'b1;
    bit rx_idle_on        = 1'b1;
    bit hold_request      = 1'b0;

    multi_signature_byte_scanner DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_sig_slot      (i_sig_slot),
        .i_byte_position (i_byte_position),
        .i_byte_value    (i_byte_value),
        .i_sig_length    (i_sig_length),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_match_slot    (o_match_slot),
        .o_match_offset  (o_match_offset),
        .o_match_length  (o_match_length),
        .o_last          (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Match predictor: update the bench state for one accepted item and queue
    // the matches that it causes, lowest slot first, last one flagged.
    // ------------------------------------------------------------------------
    task automatic predict_matches(input msbs_pkg::t_msbs_op op,
                                   input logic [SLOT_FIELD_W-1:0] slot,
                                   input logic [POS_FIELD_W-1:0] pos,
                                   input logic [BYTE_W-1:0] value,
                                   input logic [LEN_FIELD_W-1:0] len);
        int     l;
        int     n;
        logic   hit;
        t_match found [NUM_SIGS];
        n = 0;
        case (op)
            msbs_pkg::OP_LOAD_BYTE: begin
                sig_table[slot][pos]  = value;
                sig_loaded[slot][pos] = 1'b1;
            end
            msbs_pkg::OP_SET_LEN: begin
                // saturate oversized lengths to the table width
                sig_len[slot] = (len > MAX_SIG_LEN) ? LEN_FIELD_W'(MAX_SIG_LEN) : len;
            end
            msbs_pkg::OP_NEW_FILE: begin
                file_pos = 0;
            end
            default: begin
                // bytes past the scan limit are dropped without trace
                if (file_pos < SCAN_LIMIT) begin
                    recent_window[file_pos % MAX_SIG_LEN] = value;
                    file_pos++;
                    for (int s = 0; s < NUM_SIGS; s++) begin
                        l = sig_len[s];
                        // a signature longer than the file so far cannot match
                        if (l != 0 && l <= file_pos) begin
                            hit = 1'b1;
                            for (int k = 0; k < l; k++) begin
                                if (recent_window[(file_pos - l + k) % MAX_SIG_LEN]
                                        != sig_table[s][k])
                                    hit = 1'b0;
                            end
                            if (hit) begin
                                found[n].slot   = SLOT_FIELD_W'(s);
                                found[n].offset = OFFSET_W'(file_pos - l);
                                found[n].length = LEN_FIELD_W'(l);
                                found[n].last   = 1'b0;
                                n++;
                            end
                        end
                    end
                end
            end
        endcase
        for (int i = 0; i < n; i++) begin
            found[i].last = (i == n - 1);
            expected_matches.push_back(found[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Item driver: idle at random, then offer one item and hold it, payload
    // unchanged, until the handshake completes. Valid stays high afterwards
    // so that back-to-back items need no second assignment in one step.
    // ------------------------------------------------------------------------
    task automatic send_item(input msbs_pkg::t_msbs_op op,
                             input logic [SLOT_FIELD_W-1:0] slot,
                             input logic [POS_FIELD_W-1:0] pos,
                             input logic [BYTE_W-1:0] value,
                             input logic [LEN_FIELD_W-1:0] len);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_sig_slot      <= slot;
        i_byte_position <= pos;
        i_byte_value    <= value;
        i_sig_length    <= len;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        predict_matches(op, slot, pos, value, len);
    endtask

    // Fields that an operation does not use carry random values
    task automatic load_byte(input logic [SLOT_FIELD_W-1:0] slot,
                             input logic [POS_FIELD_W-1:0] pos,
                             input logic [BYTE_W-1:0] value);
        send_item(msbs_pkg::OP_LOAD_BYTE, slot, pos, value, LEN_FIELD_W'($urandom));
    endtask

    task automatic set_length(input logic [SLOT_FIELD_W-1:0] slot,
                              input logic [LEN_FIELD_W-1:0] len);
        send_item(msbs_pkg::OP_SET_LEN, slot, POS_FIELD_W'($urandom), BYTE_W'($urandom),
                  len);
    endtask

    task automatic scan_byte(input logic [BYTE_W-1:0] value);
        send_item(msbs_pkg::OP_SCAN, SLOT_FIELD_W'($urandom), POS_FIELD_W'($urandom),
                  value, LEN_FIELD_W'($urandom));
    endtask

    task automatic new_file();
        send_item(msbs_pkg::OP_NEW_FILE, SLOT_FIELD_W'($urandom), POS_FIELD_W'($urandom),
                  BYTE_W'($urandom), LEN_FIELD_W'($urandom));
    endtask

    // Count of signature bytes loaded from position zero without a gap
    function automatic int loaded_prefix(input int slot);
        int n = 0;
        while (n < MAX_SIG_LEN && sig_loaded[slot][n])
            n++;
        return n;
    endfunction

    // Pick a length that never makes the block read an unloaded byte
    function automatic logic [LEN_FIELD_W-1:0] pick_length(input int slot);
        int p = loaded_prefix(slot);
        if (p == MAX_SIG_LEN && $urandom_range(0, 1))
            return LEN_FIELD_W'($urandom_range(MAX_SIG_LEN, LEN_FIELD_MAX));
        return LEN_FIELD_W'($urandom_range(0, p));
    endfunction

    function automatic logic [BYTE_W-1:0] random_data_byte();
        if ($urandom_range(0, 99) < 85)
            return alphabet[$urandom_range(0, 3)];
        return BYTE_W'($urandom);
    endfunction

    // Load a fresh signature from the small alphabet and enable it
    task automatic program_signature();
        int slot;
        int len;
        slot = $urandom_range(0, NUM_SIGS - 1);
        len  = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6)
                                            : $urandom_range(7, MAX_SIG_LEN);
        for (int k = 0; k < len; k++)
            load_byte(SLOT_FIELD_W'(slot), POS_FIELD_W'(k), alphabet[$urandom_range(0, 3)]);
        if (len == MAX_SIG_LEN)
            set_length(SLOT_FIELD_W'(slot),
                       LEN_FIELD_W'($urandom_range(MAX_SIG_LEN, LEN_FIELD_MAX)));
        else
            set_length(SLOT_FIELD_W'(slot), LEN_FIELD_W'(len));
    endtask

    // Scan a short run of data with one enabled signature planted in it
    task automatic scan_burst();
        int                enabled [$];
        logic [BYTE_W-1:0] pattern [$];
        int                burst_len;
        int                insert_at;
        int                slot;
        for (int s = 0; s < NUM_SIGS; s++)
            if (sig_len[s] != 0)
                enabled.push_back(s);
        if (enabled.size() > 0) begin
            slot = enabled[$urandom_range(0, enabled.size() - 1)];
            for (int k = 0; k < sig_len[slot]; k++)
                pattern.push_back(sig_table[slot][k]);
        end
        burst_len = $urandom_range(4, 16);
        insert_at = $urandom_range(0, burst_len);
        for (int i = 0; i <= burst_len; i++) begin
            if (i == insert_at)
                foreach (pattern[k])
                    scan_byte(pattern[k]);
            if (i < burst_len)
                scan_byte(random_data_byte());
        end
    endtask

    // Any operation with random fields, lengths kept legal
    task automatic noise_item();
        msbs_pkg::t_msbs_op op;
        int                 slot;
        op   = msbs_pkg::t_msbs_op'($urandom_range(0, 3));
        slot = $urandom_range(0, NUM_SIGS - 1);
        case (op)
            msbs_pkg::OP_LOAD_BYTE:
                load_byte(SLOT_FIELD_W'(slot), POS_FIELD_W'($urandom), BYTE_W'($urandom));
            msbs_pkg::OP_SET_LEN:
                set_length(SLOT_FIELD_W'(slot), pick_length(slot));
            msbs_pkg::OP_SCAN:
                scan_byte(BYTE_W'($urandom));
            default:
                new_file();
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Test: reset state, single match, disable and re-enable, every slot hit
    // on one byte, and a signature longer than the file so far.
    // ------------------------------------------------------------------------
    task automatic test_directed_ops();
        scan_byte(8'h00);                   // every slot disabled after reset
        load_byte(3'd0, 5'd0, 8'h00);
        load_byte(3'd0, 5'd1, 8'hFF);
        set_length(3'd0, 6'd2);
        new_file();
        scan_byte(8'h00);
        scan_byte(8'hFF);                   // slot 0 at offset 0
        scan_byte(8'hFF);
        set_length(3'd0, 6'd0);             // disabled slot stays quiet
        scan_byte(8'h00);
        scan_byte(8'hFF);
        set_length(3'd0, 6'd2);
        for (int s = 1; s < NUM_SIGS; s++) begin
            load_byte(SLOT_FIELD_W'(s), 5'd0, 8'hFF);
            set_length(SLOT_FIELD_W'(s), 6'd1);
        end
        scan_byte(8'h00);
        scan_byte(8'hFF);                   // all eight slots on one byte
        new_file();
        scan_byte(8'hFF);                   // slot 0 too long for a 1-byte file
    endtask

    // ------------------------------------------------------------------------
    // Test: full-width signature with an oversized length saturated, matched
    // at a non-zero offset in a fresh file.
    // ------------------------------------------------------------------------
    task automatic test_long_signature();
        logic [BYTE_W-1:0] long_sig [MAX_SIG_LEN];
        int                last_slot;
        last_slot = NUM_SIGS - 1;
        foreach (long_sig[k])
            long_sig[k] = BYTE_W'($urandom);
        for (int k = 0; k < MAX_SIG_LEN; k++)
            load_byte(SLOT_FIELD_W'(last_slot), POS_FIELD_W'(k), long_sig[k]);
        set_length(SLOT_FIELD_W'(last_slot), LEN_FIELD_W'(LEN_FIELD_MAX));
        new_file();
        scan_byte(BYTE_W'($urandom));
        for (int k = 0; k < MAX_SIG_LEN; k++)
            scan_byte(long_sig[k]);
    endtask

    // ------------------------------------------------------------------------
    // Test: hold the receiver off while matching bytes keep coming, so that
    // the hit queue fills and the input stalls.
    // ------------------------------------------------------------------------
    task automatic test_backpressure();
        load_byte(3'd3, 5'd0, 8'h3C);
        set_length(3'd3, 6'd1);
        tx_idle_on   = 1'b0;
        hold_request = 1'b1;
        repeat (6) scan_byte(8'h3C);
        tx_idle_on   = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly programmed signatures and bursts that contain
    // them, with length changes, new files and noise mixed in.
    // ------------------------------------------------------------------------
    task automatic run_random_traffic(input int item_budget);
        int first_item;
        int pick;
        int slot;
        first_item = items_sent;
        foreach (alphabet[a])
            alphabet[a] = BYTE_W'($urandom);
        while (items_sent - first_item < item_budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                program_signature();
            end else if (pick < 65) begin
                scan_burst();
            end else if (pick < 78) begin
                slot = $urandom_range(0, NUM_SIGS - 1);
                set_length(SLOT_FIELD_W'(slot), pick_length(slot));
            end else if (pick < 86) begin
                new_file();
            end else begin
                noise_item();
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_traffic(10);
    endtask

    // Same traffic with no idling on either side
    task automatic test_steady_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random_traffic(15);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: idle at random, and on request hold off for a long stretch
    // counted here.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_OFF_CYCLES) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_ready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Compare each accepted result item with the oldest expected match
    always @(posedge i_clk) begin : match_checker
        t_match want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_matches.size() == 0) begin
                $error("unexpected match: slot %0d offset %0d length %0d last %0b",
                       o_match_slot, o_match_offset, o_match_length, o_last);
                error_count++;
            end else begin
                want = expected_matches.pop_front();
                if (o_match_slot !== want.slot) begin
                    $error("match_slot: expected %0d, actual %0d", want.slot, o_match_slot);
                    error_count++;
                end
                if (o_match_offset !== want.offset) begin
                    $error("match_offset: expected %0d, actual %0d",
                           want.offset, o_match_offset);
                    error_count++;
                end
                if (o_match_length !== want.length) begin
                    $error("match_length: expected %0d, actual %0d",
                           want.length, o_match_length);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT) begin
            $display("** multi_signature_byte_scanner: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: initialise inputs and bench state, reset once, run the
    // tests, drain the expected matches and report.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_operation     <= msbs_pkg::OP_LOAD_BYTE;
        i_sig_slot      <= '0;
        i_byte_position <= '0;
        i_byte_value    <= '0;
        i_sig_length    <= '0;
        file_pos = 0;
        for (int s = 0; s < NUM_SIGS; s++) begin
            sig_len[s] = '0;
            for (int k = 0; k < MAX_SIG_LEN; k++)
                sig_loaded[s][k] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_long_signature();
        test_backpressure();
        test_random_traffic();
        test_steady_stream();

        // drop valid at the step of the last accepted item
        i_valid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("** multi_signature_byte_scanner: PASSED **");
        else
            $display("** multi_signature_byte_scanner: FAILED **");
        $finish;
    end

endmodule
